@@ hw/rtl/bitmap_rectangle_set_clear_toggle_core_defines.svh @@
// Assertion macros used by the checker file.
`ifndef BITMAP_RECTANGLE_SET_CLEAR_TOGGLE_CORE_DEFINES_SVH
`define BITMAP_RECTANGLE_SET_CLEAR_TOGGLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BRSCT_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BRSCT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hw/rtl/brsct_pkg.sv @@
// Shared constants and types for the bitmap rectangle core.
package brsct_pkg;

    // WORD_BITS must be a power of two.
    localparam int GRID_SIZE     = 1024;
    localparam int WORD_BITS     = 64;
    localparam int WORDS_PER_ROW = (GRID_SIZE + WORD_BITS - 1) / WORD_BITS;
    localparam int CELL_WORDS    = GRID_SIZE * WORDS_PER_ROW;

    localparam int COORD_W = 10;
    localparam int COUNT_W = 21;
    localparam int ROW_W   = $clog2(GRID_SIZE);
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int WCOL_W  = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
    localparam int ADDR_W  = $clog2(CELL_WORDS);
    localparam int PC_W    = $clog2(WORD_BITS + 1);

    localparam logic [1:0] MODE_SET    = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_INVERT = 2'd2;
    localparam logic [1:0] MODE_NOP    = 2'd3;

    typedef struct packed {
        logic                 valid;
        logic [WORD_BITS-1:0] gain;
        logic [WORD_BITS-1:0] loss;
    } tally_req_t;

endpackage

@@ hw/rtl/brsct_tally.sv @@
// Running set-cell count: per-word popcount of gained and lost bits, then accumulate.
module brsct_tally
    import brsct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  tally_req_t         req,
    output logic               pending,
    output logic [COUNT_W-1:0] total
);

    // pairwise adder tree, log2(WORD_BITS) levels
    function automatic logic [PC_W-1:0] ones_in(input logic [WORD_BITS-1:0] w);
        logic [PC_W-1:0] lane [WORD_BITS];
        for (int i = 0; i < WORD_BITS; i++) begin
            lane[i] = PC_W'(w[i]);
        end
        for (int step = 1; step < WORD_BITS; step = step * 2) begin
            for (int i = 0; i < WORD_BITS; i = i + 2 * step) begin
                lane[i] = lane[i] + lane[i + step];
            end
        end
        return lane[0];
    endfunction

    logic               pc_valid_reg;
    logic [PC_W-1:0]    gain_cnt_reg;
    logic [PC_W-1:0]    loss_cnt_reg;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] total_next;

    always_comb
    begin
        total_next = total_reg;
        if (pc_valid_reg)
        begin
            total_next = total_reg + COUNT_W'(gain_cnt_reg) - COUNT_W'(loss_cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_valid_reg <= 1'b0;
            total_reg    <= '0;
        end
        else
        begin
            pc_valid_reg <= req.valid;
            total_reg    <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gain_cnt_reg <= ones_in(req.gain);
        loss_cnt_reg <= ones_in(req.loss);
    end

    assign pending = pc_valid_reg;
    assign total   = total_reg;

endmodule

@@ hw/rtl/bitmap_rectangle_set_clear_toggle_core.sv @@
// Top level: bitmap rectangle set / clear / invert with running set-cell count.
//
// Command channel: a request (mode, row_first, col_first, row_last, col_last)
// is taken at a rising edge where start is high and busy is low.
// Result channel: done pulses for one cycle with set_count, the number of set
// cells in the whole bitmap after the request. Exactly one result per request;
// the receiver cannot stall, so done is never held.
// The bitmap sits in one single-port-write, registered-read memory of
// GRID_SIZE * WORDS_PER_ROW words; each spanned word is read, modified and
// written back, one word per cycle.
// A no-op or empty rectangle goes straight to the done state, so done follows
// in the next cycle. Otherwise the request walks the scan state over N words,
// N = rows spanned times words spanned per row, then waits in the drain state
// until the write-back and tally pipeline is empty. busy stays high until done.
// Reset: the count clears at once; busy then stays high while a sweep writes
// zeros through every memory word.
module bitmap_rectangle_set_clear_toggle_core
    import brsct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [COORD_W-1:0] row_first,
    input  logic [COORD_W-1:0] col_first,
    input  logic [COORD_W-1:0] row_last,
    input  logic [COORD_W-1:0] col_last,
    output logic               done,
    output logic [COUNT_W-1:0] set_count
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [WORD_BITS-1:0] cell_mem [CELL_WORDS];

    logic [2:0]           state_reg, state_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [1:0]           mode_reg, mode_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [ROW_W-1:0]     row_end_reg, row_end_next;
    logic [WCOL_W-1:0]    wcol_reg, wcol_next;
    logic [WCOL_W-1:0]    wcol_first_reg, wcol_first_next;
    logic [WCOL_W-1:0]    wcol_last_reg, wcol_last_next;
    logic [BIT_W-1:0]     bit_first_reg, bit_first_next;
    logic [BIT_W-1:0]     bit_last_reg, bit_last_next;

    logic                 p1_valid_reg;
    logic [ADDR_W-1:0]    p1_addr_reg;
    logic [WORD_BITS-1:0] p1_mask_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    tally_req_t           tally_req_reg, tally_req_next;

    logic [31:0]          rf_w, cf_w, rl_w, cl_w, rl_c, cl_c;
    logic                 cmd_live;
    logic                 accept;
    logic                 scan_issue;
    logic [ADDR_W-1:0]    scan_addr;
    logic [BIT_W-1:0]     lo_bit, hi_bit;
    logic [WORD_BITS-1:0] scan_mask;
    logic [WORD_BITS-1:0] new_word;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 tally_pending;
    logic [COUNT_W-1:0]   tally_total;

    // request decode: clamp last corner, detect empty / no-op
    always_comb
    begin
        rf_w = 32'(row_first);
        cf_w = 32'(col_first);
        rl_w = 32'(row_last);
        cl_w = 32'(col_last);
        rl_c = (rl_w >= 32'(GRID_SIZE)) ? 32'(GRID_SIZE - 1) : rl_w;
        cl_c = (cl_w >= 32'(GRID_SIZE)) ? 32'(GRID_SIZE - 1) : cl_w;
        cmd_live = (mode != MODE_NOP) && (rf_w < 32'(GRID_SIZE)) &&
                   (cf_w < 32'(GRID_SIZE)) && (rf_w <= rl_c) && (cf_w <= cl_c);
    end

    assign accept     = start && (state_reg == ST_IDLE);
    assign scan_issue = (state_reg == ST_SCAN);
    assign scan_addr  = ADDR_W'(row_reg) * ADDR_W'(WORDS_PER_ROW) + ADDR_W'(wcol_reg);

    always_comb
    begin
        lo_bit    = (wcol_reg == wcol_first_reg) ? bit_first_reg : '0;
        hi_bit    = (wcol_reg == wcol_last_reg) ? bit_last_reg : BIT_W'(WORD_BITS - 1);
        scan_mask = ({WORD_BITS{1'b1}} << lo_bit) &
                    ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit));
    end

    always_comb
    begin
        unique case (mode_reg)
            MODE_SET:    new_word = rd_data_reg | p1_mask_reg;
            MODE_CLEAR:  new_word = rd_data_reg & ~p1_mask_reg;
            MODE_INVERT: new_word = rd_data_reg ^ p1_mask_reg;
            default:     new_word = rd_data_reg;
        endcase
    end

    always_comb
    begin
        tally_req_next.valid = p1_valid_reg;
        tally_req_next.gain  = new_word & ~rd_data_reg;
        tally_req_next.loss  = rd_data_reg & ~new_word;
    end

    always_comb
    begin
        mem_we    = (state_reg == ST_CLEAR) || p1_valid_reg;
        mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : p1_addr_reg;
        mem_wdata = (state_reg == ST_CLEAR) ? '0 : new_word;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        mode_next       = mode_reg;
        row_next        = row_reg;
        row_end_next    = row_end_reg;
        wcol_next       = wcol_reg;
        wcol_first_next = wcol_first_reg;
        wcol_last_next  = wcol_last_reg;
        bit_first_next  = bit_first_reg;
        bit_last_next   = bit_last_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(CELL_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next       = mode;
                    row_next        = ROW_W'(rf_w);
                    row_end_next    = ROW_W'(rl_c);
                    wcol_next       = WCOL_W'(cf_w >> BIT_W);
                    wcol_first_next = WCOL_W'(cf_w >> BIT_W);
                    wcol_last_next  = WCOL_W'(cl_c >> BIT_W);
                    bit_first_next  = cf_w[BIT_W-1:0];
                    bit_last_next   = cl_c[BIT_W-1:0];
                    state_next      = cmd_live ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (wcol_reg == wcol_last_reg)
                begin
                    wcol_next = wcol_first_reg;
                    row_next  = ROW_W'(row_reg + 1'b1);
                    if (row_reg == row_end_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    wcol_next = WCOL_W'(wcol_reg + 1'b1);
                end
            end
            ST_DRAIN:
            begin
                if (!p1_valid_reg && !tally_req_reg.valid && !tally_pending)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            p1_valid_reg  <= 1'b0;
            tally_req_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            p1_valid_reg  <= scan_issue;
            tally_req_reg <= tally_req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        row_reg        <= row_next;
        row_end_reg    <= row_end_next;
        wcol_reg       <= wcol_next;
        wcol_first_reg <= wcol_first_next;
        wcol_last_reg  <= wcol_last_next;
        bit_first_reg  <= bit_first_next;
        bit_last_reg   <= bit_last_next;
        p1_addr_reg    <= scan_addr;
        p1_mask_reg    <= scan_mask;
    end

    // bitmap store: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= cell_mem[scan_addr];
    end

    brsct_tally u_tally (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tally_req_reg),
        .pending (tally_pending),
        .total   (tally_total)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign done      = (state_reg == ST_DONE);
    assign set_count = tally_total;

endmodule

@@ hw/rtl/brsct_checker.sv @@
// Port-level checks for the bitmap rectangle core, bound to the top level.
`include "bitmap_rectangle_set_clear_toggle_core_defines.svh"

module brsct_checker
    import brsct_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         mode,
    input logic               done,
    input logic [COUNT_W-1:0] set_count
);

    // a result only closes out a request in flight
    `BRSCT_ASSERT_NOW(a_done_while_busy, clk, rst_n, done, busy)

    // accepted request holds off the next one
    `BRSCT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // no-op request answers in the following cycle
    `BRSCT_ASSERT_NEXT(a_nop_fast, clk, rst_n, start && !busy && (mode == MODE_NOP), done)

    // count moves only while a request is worked
    `BRSCT_ASSERT_NEXT(a_count_idle, clk, rst_n, !busy && !start, $stable(set_count))

endmodule

bind bitmap_rectangle_set_clear_toggle_core brsct_checker u_brsct_checker (.*);

@@ tb/sv/bitmap_rectangle_set_clear_toggle_core_tb.sv @@
// Self-checking testbench for the bitmap rectangle set / clear / invert core.
`timescale 1ns / 1ps

module bitmap_rectangle_set_clear_toggle_core_tb;
    import brsct_pkg::*;

    typedef struct {
        logic [1:0]         mode;
        logic [COORD_W-1:0] row_first;
        logic [COORD_W-1:0] col_first;
        logic [COORD_W-1:0] row_last;
        logic [COORD_W-1:0] col_last;
        bit                 has_count;
        logic [COUNT_W-1:0] count;
    } rect_req_t;

    localparam int NUM_DIRECTED = 20;
    localparam int NUM_RANDOM   = 80;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         mode;
    logic [COORD_W-1:0] row_first;
    logic [COORD_W-1:0] col_first;
    logic [COORD_W-1:0] row_last;
    logic [COORD_W-1:0] col_last;
    logic               done;
    logic [COUNT_W-1:0] set_count;

    bit [WORD_BITS-1:0] cell_words [CELL_WORDS];
    logic [COUNT_W-1:0] lit_cells = '0;
    logic [COUNT_W-1:0] pending_counts [$];
    int                 mismatch_count = 0;
    int                 burst_left = 0;

    // count column is typed in only where it is obvious; other rows use the predictor
    rect_req_t directed_reqs [NUM_DIRECTED] = '{
        '{MODE_NOP,    10'd0,    10'd0,    10'd1023, 10'd1023, 1'b1, 21'd0},
        '{MODE_SET,    10'd0,    10'd0,    10'd1023, 10'd1023, 1'b1, 21'd1048576},
        '{MODE_NOP,    10'd1023, 10'd1023, 10'd0,    10'd0,    1'b1, 21'd1048576},
        '{MODE_CLEAR,  10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1, 21'd1048575},
        '{MODE_INVERT, 10'd0,    10'd0,    10'd1023, 10'd1023, 1'b1, 21'd1},
        '{MODE_CLEAR,  10'd0,    10'd0,    10'd1023, 10'd1023, 1'b1, 21'd0},
        '{MODE_SET,    10'd5,    10'd10,   10'd4,    10'd20,   1'b1, 21'd0},
        '{MODE_SET,    10'd5,    10'd20,   10'd6,    10'd10,   1'b1, 21'd0},
        '{MODE_SET,    10'd0,    10'd0,    10'd0,    10'd0,    1'b1, 21'd1},
        '{MODE_INVERT, 10'd0,    10'd0,    10'd0,    10'd1,    1'b1, 21'd1},
        '{MODE_SET,    10'd0,    10'd63,   10'd0,    10'd64,   1'b1, 21'd3},
        '{MODE_SET,    10'd1,    10'd0,    10'd1,    10'd1023, 1'b1, 21'd1027},
        '{MODE_INVERT, 10'd0,    10'd0,    10'd1023, 10'd0,    1'b0, 21'd0},
        '{MODE_SET,    10'd100,  10'd1000, 10'd200,  10'd1023, 1'b0, 21'd0},
        '{MODE_CLEAR,  10'd0,    10'd0,    10'd1023, 10'd1023, 1'b1, 21'd0},
        '{MODE_SET,    10'd682,  10'd341,  10'd682,  10'd341,  1'b1, 21'd1},
        '{MODE_INVERT, 10'd341,  10'd682,  10'd341,  10'd682,  1'b1, 21'd2},
        '{MODE_SET,    10'd1023, 10'd0,    10'd1023, 10'd1023, 1'b0, 21'd0},
        '{MODE_INVERT, 10'd512,  10'd511,  10'd515,  10'd576,  1'b0, 21'd0},
        '{MODE_CLEAR,  10'd1023, 10'd1023, 10'd0,    10'd0,    1'b0, 21'd0}
    };

    bitmap_rectangle_set_clear_toggle_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .row_first (row_first),
        .col_first (col_first),
        .row_last  (row_last),
        .col_last  (col_last),
        .done      (done),
        .set_count (set_count)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #100_000_000;
        $display("FAIL bitmap_rectangle_set_clear_toggle_core");
        $finish;
    end

    function automatic logic [COUNT_W-1:0] fill_rect(input rect_req_t req);
        int                 rf, cf, rl, cl;
        int                 w_lo, w_hi, lo, hi, idx;
        bit [WORD_BITS-1:0] mask, was, now;
        rf = int'(req.row_first);
        cf = int'(req.col_first);
        rl = int'(req.row_last);
        cl = int'(req.col_last);
        if (rl >= GRID_SIZE) rl = GRID_SIZE - 1;
        if (cl >= GRID_SIZE) cl = GRID_SIZE - 1;
        if (req.mode != MODE_NOP && rf < GRID_SIZE && cf < GRID_SIZE && rf <= rl && cf <= cl)
        begin
            w_lo = cf / WORD_BITS;
            w_hi = cl / WORD_BITS;
            for (int r = rf; r <= rl; r++)
            begin
                for (int w = w_lo; w <= w_hi; w++)
                begin
                    lo   = (w == w_lo) ? cf % WORD_BITS : 0;
                    hi   = (w == w_hi) ? cl % WORD_BITS : WORD_BITS - 1;
                    mask = ({WORD_BITS{1'b1}} >> (WORD_BITS - 1 - hi)) &
                           ({WORD_BITS{1'b1}} << lo);
                    idx  = r * WORDS_PER_ROW + w;
                    was  = cell_words[idx];
                    case (req.mode)
                        MODE_SET:   now = was | mask;
                        MODE_CLEAR: now = was & ~mask;
                        default:    now = was ^ mask;
                    endcase
                    cell_words[idx] = now;
                    lit_cells = COUNT_W'(int'(lit_cells) + $countones(now & mask)
                                         - $countones(was & mask));
                end
            end
        end
        return lit_cells;
    endfunction

    function automatic rect_req_t random_rect();
        rect_req_t req;
        int        kind, rf, cf, rl, cl;
        kind = $urandom_range(0, 99);
        rf   = $urandom_range(0, GRID_SIZE - 1);
        cf   = $urandom_range(0, GRID_SIZE - 1);
        if (kind < 3)
        begin
            rf = $urandom_range(0, 15);
            cf = $urandom_range(0, 63);
            rl = $urandom_range(GRID_SIZE - 16, GRID_SIZE - 1);
            cl = $urandom_range(GRID_SIZE - 64, GRID_SIZE - 1);
        end
        else if (kind < 15)
        begin
            rl = rf + $urandom_range(0, 63);
            cl = $urandom_range(cf, GRID_SIZE - 1);
        end
        else if (kind < 25)
        begin
            if (rf == 0) rf = 1;
            rl = $urandom_range(0, rf - 1);
            cl = $urandom_range(0, GRID_SIZE - 1);
        end
        else
        begin
            rl = rf + $urandom_range(0, 7);
            cl = cf + $urandom_range(0, 150);
        end
        if (rl > GRID_SIZE - 1) rl = GRID_SIZE - 1;
        if (cl > GRID_SIZE - 1) cl = GRID_SIZE - 1;
        req.mode      = 2'($urandom_range(0, 3));
        req.row_first = COORD_W'(rf);
        req.col_first = COORD_W'(cf);
        req.row_last  = COORD_W'(rl);
        req.col_last  = COORD_W'(cl);
        req.has_count = 1'b0;
        req.count     = '0;
        return req;
    endfunction

    task automatic send_rect(input rect_req_t req);
        logic [COUNT_W-1:0] predicted;
        int                 gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        mode      <= req.mode;
        row_first <= req.row_first;
        col_first <= req.col_first;
        row_last  <= req.row_last;
        col_last  <= req.col_last;
        start     <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        predicted = fill_rect(req);
        pending_counts.push_back(req.has_count ? req.count : predicted);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_counts.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_counts.size() == 0)
            begin
                $error("set_count: expected none, actual %0d", set_count);
                mismatch_count++;
            end
            else
            begin
                if (set_count !== pending_counts[0])
                begin
                    $error("set_count: expected %0d, actual %0d", pending_counts[0], set_count);
                    mismatch_count++;
                end
                void'(pending_counts.pop_front());
            end
        end
    end

    initial begin
        rst_n     = 1'b0;
        start     = 1'b0;
        mode      = MODE_NOP;
        row_first = '0;
        col_first = '0;
        row_last  = '0;
        col_last  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_reqs[i])
            send_rect(directed_reqs[i]);
        drain();

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            send_rect(random_rect());
            if (i % 30 == 29)
                drain();
        end

        start <= 1'b0;
        while (pending_counts.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0 && pending_counts.size() == 0)
            $display("PASS bitmap_rectangle_set_clear_toggle_core");
        else
            $display("FAIL bitmap_rectangle_set_clear_toggle_core");
        $finish;
    end

endmodule
